// File: hw/rtl/three_operand_cpu_execute_unit_assert.svh
// Assertion macros for the execute unit. Each macro checks on the rising
// edge of clk and is disabled while rst_n is low.
`ifndef THREE_OPERAND_CPU_EXECUTE_UNIT_ASSERT_SVH
`define THREE_OPERAND_CPU_EXECUTE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define TOEU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TOEU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TOEU_ASSERT_IMP(label, ante, cons, msg)
`define TOEU_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

// File: hw/rtl/toeu_pkg.sv
package toeu_pkg;

    localparam int XLEN      = 32;
    localparam int PC_W      = 12;
    localparam int IDX_W     = 4;
    localparam int CMD_W     = 5;
    localparam int REG_COUNT = 16;
    localparam int RF_AW     = $clog2(REG_COUNT);
    localparam int MEM_WORDS = 4096;
    localparam int DM_AW     = $clog2(MEM_WORDS);

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 5'd0,
        CMD_SUB    = 5'd1,
        CMD_MAC    = 5'd2,
        CMD_AND    = 5'd3,
        CMD_OR     = 5'd4,
        CMD_XOR    = 5'd5,
        CMD_SLL    = 5'd6,
        CMD_SRA    = 5'd7,
        CMD_SRL    = 5'd8,
        CMD_BEQ    = 5'd9,
        CMD_BNE    = 5'd10,
        CMD_BLT    = 5'd11,
        CMD_BGT    = 5'd12,
        CMD_BLE    = 5'd13,
        CMD_BGE    = 5'd14,
        CMD_JAL    = 5'd15,
        CMD_LW     = 5'd16,
        CMD_SW     = 5'd17,
        CMD_SETREG = 5'd18
    } cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0]       command;
        logic [IDX_W-1:0]       dest_index;
        logic [IDX_W-1:0]       src_s_index;
        logic [IDX_W-1:0]       src_t_index;
        logic [IDX_W-1:0]       src_m_index;
        logic signed [XLEN-1:0] load_value;
    } instr_word_t;

    typedef struct packed {
        logic [PC_W-1:0]        next_pc;
        logic                   reg_written;
        logic [IDX_W-1:0]       reg_index;
        logic signed [XLEN-1:0] reg_value;
        logic                   mem_written;
        logic [PC_W-1:0]        mem_address;
        logic signed [XLEN-1:0] mem_value;
        logic                   fault;
    } result_word_t;

    // Operands of the item in the execute stage, after forwarding.
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [RF_AW-1:0] rd;
        logic [RF_AW-1:0] rm;
        logic [PC_W-1:0]  pc;
        logic [XLEN-1:0]  vs;
        logic [XLEN-1:0]  vt;
        logic [XLEN-1:0]  vm;
        logic [XLEN-1:0]  vd;
        logic [XLEN-1:0]  load_value;
    } alu_in_t;

    // For a load, rval carries the addend; the loaded word is added later.
    typedef struct packed {
        logic             rw;
        logic             is_load;
        logic             mw;
        logic             fault;
        logic [PC_W-1:0]  npc;
        logic [PC_W-1:0]  maddr;
        logic [DM_AW-1:0] dm_addr;
        logic [XLEN-1:0]  rval;
        logic [XLEN-1:0]  mval;
    } alu_res_t;

    // Register index, taken modulo the register count (a power of two).
    function automatic logic [RF_AW-1:0] reg_sel(input logic [IDX_W-1:0] idx);
        return RF_AW'(idx);
    endfunction

endpackage

// File: hw/rtl/toeu_ram_2r.sv
// Synchronous RAM, one write port, two registered read ports.
module toeu_ram_2r #(
    parameter int AW = 4,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [DW-1:0] rdata_a,
    output logic [DW-1:0] rdata_b
);

    localparam int DEPTH = 1 << AW;

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// File: hw/rtl/toeu_alu.sv
// Execute-stage datapath: ALU, branch resolve, address generation.
module toeu_alu (
    input  toeu_pkg::alu_in_t  op,
    output toeu_pkg::alu_res_t res
);

    logic [toeu_pkg::PC_W-1:0] seq;
    logic [toeu_pkg::XLEN-1:0] addr;
    logic [toeu_pkg::XLEN-1:0] prod;
    logic [4:0]                sh;
    logic                      taken;
    logic                      oob;

    always_comb
    begin
        seq  = op.pc + toeu_pkg::PC_W'(1);
        addr = op.vs + op.vt;
        prod = op.vs * op.vt;
        sh   = op.vt[4:0];
        oob  = addr >= toeu_pkg::XLEN'(toeu_pkg::MEM_WORDS);

        case (toeu_pkg::cmd_t'(op.command))
            toeu_pkg::CMD_BEQ: taken = op.vs == op.vt;
            toeu_pkg::CMD_BNE: taken = op.vs != op.vt;
            toeu_pkg::CMD_BLT: taken = $signed(op.vs) <  $signed(op.vt);
            toeu_pkg::CMD_BGT: taken = $signed(op.vs) >  $signed(op.vt);
            toeu_pkg::CMD_BLE: taken = $signed(op.vs) <= $signed(op.vt);
            default:           taken = $signed(op.vs) >= $signed(op.vt);
        endcase

        res         = '0;
        res.npc     = seq;
        res.dm_addr = addr[toeu_pkg::DM_AW-1:0];

        case (toeu_pkg::cmd_t'(op.command))
            toeu_pkg::CMD_ADD:
            begin
                res.rval = op.vs + op.vt + op.vm;
                res.rw   = 1'b1;
            end
            toeu_pkg::CMD_SUB:
            begin
                res.rval = op.vs - op.vt - op.vm;
                res.rw   = 1'b1;
            end
            toeu_pkg::CMD_MAC:
            begin
                res.rval = prod + op.vm;
                res.rw   = 1'b1;
            end
            toeu_pkg::CMD_AND:
            begin
                res.rval = op.vs & op.vt & op.vm;
                res.rw   = 1'b1;
            end
            toeu_pkg::CMD_OR:
            begin
                res.rval = op.vs | op.vt | op.vm;
                res.rw   = 1'b1;
            end
            toeu_pkg::CMD_XOR:
            begin
                res.rval = op.vs ^ op.vt ^ op.vm;
                res.rw   = 1'b1;
            end
            toeu_pkg::CMD_SLL:
            begin
                res.rval = op.vs << sh;
                res.rw   = 1'b1;
            end
            toeu_pkg::CMD_SRA:
            begin
                res.rval = $unsigned($signed(op.vs) >>> sh);
                res.rw   = 1'b1;
            end
            toeu_pkg::CMD_SRL:
            begin
                res.rval = op.vs >> sh;
                res.rw   = 1'b1;
            end
            toeu_pkg::CMD_BEQ, toeu_pkg::CMD_BNE, toeu_pkg::CMD_BLT,
            toeu_pkg::CMD_BGT, toeu_pkg::CMD_BLE, toeu_pkg::CMD_BGE:
            begin
                if (taken)
                begin
                    res.npc = op.vm[toeu_pkg::PC_W-1:0];
                end
            end
            toeu_pkg::CMD_JAL:
            begin
                // link is written before the target is read
                res.rval = toeu_pkg::XLEN'(seq);
                res.rw   = 1'b1;
                res.npc  = (op.rd == op.rm) ? seq : op.vm[toeu_pkg::PC_W-1:0];
            end
            toeu_pkg::CMD_LW, toeu_pkg::CMD_SW:
            begin
                res.maddr = addr[toeu_pkg::PC_W-1:0];
                if (oob)
                begin
                    res.fault = 1'b1;
                    res.npc   = op.pc;
                end
                else if (toeu_pkg::cmd_t'(op.command) == toeu_pkg::CMD_LW)
                begin
                    res.is_load = 1'b1;
                    res.rw      = 1'b1;
                    res.rval    = op.vm;
                end
                else
                begin
                    res.mw   = 1'b1;
                    res.mval = op.vd + op.vm;
                end
            end
            toeu_pkg::CMD_SETREG:
            begin
                res.rval = op.load_value;
                res.rw   = 1'b1;
                res.npc  = op.pc;
            end
            default:
            begin
                res.rw = 1'b0;
            end
        endcase
    end

endmodule

// File: hw/rtl/three_operand_cpu_execute_unit.sv
// Three-operand execute unit: register file, program counter, data memory.
//
// instr channel (instr_valid/instr_ready/instr) takes one decoded word per
// cycle unless stalled; result channel (result_valid/result_ready/result)
// returns one word per instruction, in order.
// Pipeline: E (operands from the register file RAM, ALU, address, store),
// M (loaded word arrives, register file write), O (output register).
// Throughput: one word per cycle while nothing stalls. A word that reads a
// register loaded by the word just ahead of it waits in E until the load
// has left M: the loaded value comes out of the data RAM's registered read
// port and is forwarded only after it is written back.
// Reset: PC zero. The register file and data RAM are cleared by a sweep over
// all MEM_WORDS (4096) data RAM addresses, one entry of each per cycle;
// instr_ready stays low until it ends.
// When result_ready is low, O holds its word, and M and E fill and then
// hold; instr_ready drops once E can no longer move.
`include "three_operand_cpu_execute_unit_assert.svh"

module three_operand_cpu_execute_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   instr_valid,
    output logic                   instr_ready,
    input  toeu_pkg::instr_word_t  instr,
    output logic                   result_valid,
    input  logic                   result_ready,
    output toeu_pkg::result_word_t result
);

    localparam int RF_AW = toeu_pkg::RF_AW;
    localparam int DM_AW = toeu_pkg::DM_AW;
    localparam int XLEN  = toeu_pkg::XLEN;
    localparam int PC_W  = toeu_pkg::PC_W;

    // ---------------- clear sweep after reset ----------------
    logic             clr_busy_reg, clr_busy_next;
    logic [DM_AW-1:0] clr_addr_reg, clr_addr_next;

    // ---------------- pipeline control ----------------
    logic accept;
    logic e_go, m_go, e_stall;
    logic e_valid_reg, e_valid_next;
    logic m_valid_reg, m_valid_next;
    logic o_valid_reg, o_valid_next;

    toeu_pkg::instr_word_t  e_instr_reg;
    toeu_pkg::alu_res_t     m_res_reg;
    logic [RF_AW-1:0]       m_rd_reg;
    toeu_pkg::result_word_t o_word_reg;
    toeu_pkg::result_word_t m_word;

    logic [PC_W-1:0] pc_reg, pc_next;

    // E-stage indices
    logic [RF_AW-1:0] e_rd, e_rs, e_rt, e_rm;

    // register file
    logic             rf_we;
    logic [RF_AW-1:0] rf_waddr;
    logic [XLEN-1:0]  rf_wdata;
    logic [RF_AW-1:0] ra_s, ra_t, ra_m, ra_d;
    logic [XLEN-1:0]  rq_s, rq_t, rq_m, rq_d;

    // last write-back, for the read that coincided with it
    logic             w_valid_reg, w_valid_next;
    logic [RF_AW-1:0] w_idx_reg;
    logic [XLEN-1:0]  w_data_reg;

    // data RAM
    logic [XLEN-1:0]  dm [toeu_pkg::MEM_WORDS];
    logic [XLEN-1:0]  dm_rdata_reg;
    logic             dm_we;
    logic [DM_AW-1:0] dm_waddr;
    logic [XLEN-1:0]  dm_wdata;

    logic [XLEN-1:0]    m_final_rval;
    toeu_pkg::alu_in_t  alu_op;
    toeu_pkg::alu_res_t alu_res;

    // assertion helpers
    logic clr_last;
    logic o_wrote;

    function automatic logic [XLEN-1:0] fwd(
        input logic [RF_AW-1:0] idx,
        input logic [XLEN-1:0]  raw,
        input logic             m_hit_en,
        input logic [RF_AW-1:0] m_idx,
        input logic [XLEN-1:0]  m_val,
        input logic             w_en,
        input logic [RF_AW-1:0] w_idx,
        input logic [XLEN-1:0]  w_val
    );
        if (m_hit_en && (m_idx == idx))
        begin
            return m_val;
        end
        else if (w_en && (w_idx == idx))
        begin
            return w_val;
        end
        return raw;
    endfunction

    // ---------------- clear sweep ----------------
    always_comb
    begin
        clr_addr_next = clr_addr_reg + DM_AW'(1);
        clr_busy_next = clr_busy_reg && (clr_addr_reg != DM_AW'(toeu_pkg::MEM_WORDS - 1));
    end

    // ---------------- handshake and stage control ----------------
    assign e_rd = toeu_pkg::reg_sel(e_instr_reg.dest_index);
    assign e_rs = toeu_pkg::reg_sel(e_instr_reg.src_s_index);
    assign e_rt = toeu_pkg::reg_sel(e_instr_reg.src_t_index);
    assign e_rm = toeu_pkg::reg_sel(e_instr_reg.src_m_index);

    // load-use: the loaded value is not forwardable from M
    assign e_stall = e_valid_reg && m_valid_reg && m_res_reg.is_load &&
                     ((m_rd_reg == e_rs) || (m_rd_reg == e_rt) ||
                      (m_rd_reg == e_rm) || (m_rd_reg == e_rd));

    assign m_go        = m_valid_reg && (!o_valid_reg || result_ready);
    assign e_go        = e_valid_reg && !e_stall && (!m_valid_reg || m_go);
    assign instr_ready = !clr_busy_reg && (!e_valid_reg || e_go);
    assign accept      = instr_valid && instr_ready;

    always_comb
    begin
        e_valid_next = accept ? 1'b1 : (e_go ? 1'b0 : e_valid_reg);
        m_valid_next = e_go ? 1'b1 : (m_go ? 1'b0 : m_valid_reg);
        o_valid_next = m_go ? 1'b1 : (result_ready ? 1'b0 : o_valid_reg);
        pc_next      = e_go ? alu_res.npc : pc_reg;
        w_valid_next = m_go && m_res_reg.rw;
    end

    // ---------------- register file (two copies, two reads each) ----------------
    // Read every cycle: new indices on accept, otherwise re-read E's own.
    always_comb
    begin
        if (accept)
        begin
            ra_s = toeu_pkg::reg_sel(instr.src_s_index);
            ra_t = toeu_pkg::reg_sel(instr.src_t_index);
            ra_m = toeu_pkg::reg_sel(instr.src_m_index);
            ra_d = toeu_pkg::reg_sel(instr.dest_index);
        end
        else
        begin
            ra_s = e_rs;
            ra_t = e_rt;
            ra_m = e_rm;
            ra_d = e_rd;
        end
    end

    assign m_final_rval = m_res_reg.is_load ? (dm_rdata_reg + m_res_reg.rval) : m_res_reg.rval;

    // sweep reuses the write port; MEM_WORDS >= REG_COUNT covers every register
    always_comb
    begin
        rf_we    = clr_busy_reg || (m_go && m_res_reg.rw);
        rf_waddr = clr_busy_reg ? clr_addr_reg[RF_AW-1:0] : m_rd_reg;
        rf_wdata = clr_busy_reg ? '0 : m_final_rval;
    end

    toeu_ram_2r #(
        .AW (RF_AW),
        .DW (XLEN)
    ) u_rf_st (
        .clk     (clk),
        .we      (rf_we),
        .waddr   (rf_waddr),
        .wdata   (rf_wdata),
        .raddr_a (ra_s),
        .raddr_b (ra_t),
        .rdata_a (rq_s),
        .rdata_b (rq_t)
    );

    toeu_ram_2r #(
        .AW (RF_AW),
        .DW (XLEN)
    ) u_rf_md (
        .clk     (clk),
        .we      (rf_we),
        .waddr   (rf_waddr),
        .wdata   (rf_wdata),
        .raddr_a (ra_m),
        .raddr_b (ra_d),
        .rdata_a (rq_m),
        .rdata_b (rq_d)
    );

    // ---------------- execute stage ----------------
    // Priority: M (not yet written), then the write that raced the read, then RAM.
    always_comb
    begin
        alu_op.command    = e_instr_reg.command;
        alu_op.rd         = e_rd;
        alu_op.rm         = e_rm;
        alu_op.pc         = pc_reg;
        alu_op.load_value = e_instr_reg.load_value;
        alu_op.vs = fwd(e_rs, rq_s, m_valid_reg && m_res_reg.rw, m_rd_reg, m_res_reg.rval,
                        w_valid_reg, w_idx_reg, w_data_reg);
        alu_op.vt = fwd(e_rt, rq_t, m_valid_reg && m_res_reg.rw, m_rd_reg, m_res_reg.rval,
                        w_valid_reg, w_idx_reg, w_data_reg);
        alu_op.vm = fwd(e_rm, rq_m, m_valid_reg && m_res_reg.rw, m_rd_reg, m_res_reg.rval,
                        w_valid_reg, w_idx_reg, w_data_reg);
        alu_op.vd = fwd(e_rd, rq_d, m_valid_reg && m_res_reg.rw, m_rd_reg, m_res_reg.rval,
                        w_valid_reg, w_idx_reg, w_data_reg);
    end

    toeu_alu u_alu (
        .op  (alu_op),
        .res (alu_res)
    );

    // ---------------- data RAM ----------------
    // A store writes at the end of E; a later load reads at a later edge,
    // so the RAM itself orders them.
    always_comb
    begin
        dm_we    = clr_busy_reg || (e_go && alu_res.mw);
        dm_waddr = clr_busy_reg ? clr_addr_reg : alu_res.dm_addr;
        dm_wdata = clr_busy_reg ? '0 : alu_res.mval;
    end

    always_ff @(posedge clk)
    begin
        if (dm_we)
        begin
            dm[dm_waddr] <= dm_wdata;
        end
        if (e_go && alu_res.is_load)
        begin
            dm_rdata_reg <= dm[alu_res.dm_addr];
        end
    end

    // ---------------- M stage result word ----------------
    always_comb
    begin
        m_word.next_pc     = m_res_reg.npc;
        m_word.reg_written = m_res_reg.rw;
        m_word.reg_index   = m_res_reg.rw ? toeu_pkg::IDX_W'(m_rd_reg) : '0;
        m_word.reg_value   = m_res_reg.rw ? m_final_rval : '0;
        m_word.mem_written = m_res_reg.mw;
        m_word.mem_address = m_res_reg.maddr;
        m_word.mem_value   = m_res_reg.is_load ? dm_rdata_reg : m_res_reg.mval;
        m_word.fault       = m_res_reg.fault;
    end

    assign result_valid = o_valid_reg;
    assign result       = o_word_reg;

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            e_valid_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            o_valid_reg  <= 1'b0;
            w_valid_reg  <= 1'b0;
            pc_reg       <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
            e_valid_reg  <= e_valid_next;
            m_valid_reg  <= m_valid_next;
            o_valid_reg  <= o_valid_next;
            w_valid_reg  <= w_valid_next;
            pc_reg       <= pc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            e_instr_reg <= instr;
        end
        if (e_go)
        begin
            m_res_reg <= alu_res;
            m_rd_reg  <= e_rd;
        end
        if (m_go)
        begin
            o_word_reg <= m_word;
            w_idx_reg  <= m_rd_reg;
            w_data_reg <= m_final_rval;
        end
    end

    // ---------------- assertions ----------------
    assign clr_last = clr_busy_reg && (clr_addr_reg == DM_AW'(toeu_pkg::MEM_WORDS - 1));
    assign o_wrote  = o_word_reg.reg_written || o_word_reg.mem_written;

    `TOEU_ASSERT_NXT(a_accept_fills_e, accept, e_valid_reg, "accepted word missing in E")
    `TOEU_ASSERT_IMP(a_stall_needs_load, e_stall, m_valid_reg && m_res_reg.is_load, "no load in M")
    `TOEU_ASSERT_IMP(a_fault_no_write, o_valid_reg && o_word_reg.fault, !o_wrote, "fault wrote")
    `TOEU_ASSERT_NXT(a_clear_ends, clr_last, !clr_busy_reg && !m_valid_reg, "sweep did not end")

endmodule

// File: test/tb_three_operand_cpu_execute_unit.sv
module tb_three_operand_cpu_execute_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import toeu_pkg::*;

    // Commands past CMD_SETREG decode to nothing: no write, PC advances.
    localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = 5'd19;
    localparam logic [CMD_W-1:0] CMD_LAST_UNUSED  = 5'd31;

    // Slowest legal run: the clear sweep, then ~1100 words, each facing up to
    // the longest send gap and the longest result stall; allow several times that.
    localparam int CYCLE_LIMIT  = 600_000;
    localparam int MAX_REPORTS  = 50;
    localparam int RANDOM_WORDS = 1050;
    localparam int DRAIN_EVERY  = 350;

    logic         clk;
    logic         rst_n;
    logic         instr_valid;
    logic         instr_ready;
    instr_word_t  instr;
    logic         result_valid;
    logic         result_ready;
    result_word_t result;

    three_operand_cpu_execute_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .instr_valid  (instr_valid),
        .instr_ready  (instr_ready),
        .instr        (instr),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // ------------------------------------------------------------------
    // Architectural shadow state, advanced once per accepted instruction.
    // ------------------------------------------------------------------
    logic [XLEN-1:0] arch_regs [REG_COUNT];
    logic [XLEN-1:0] arch_mem  [MEM_WORDS];
    logic [PC_W-1:0] arch_pc;

    // Result words predicted but not yet seen on the result channel.
    result_word_t pending_results [$];

    int mismatches;
    int words_sent;
    int words_checked;
    int n_loads;
    int n_stores;
    int n_faults;
    int n_taken;
    int n_jumps;
    int cycle_count;

    // Length of a no-gap stretch still running on each side.
    int tx_run;
    int rx_run;
    int rx_stall;

    // ------------------------------------------------------------------
    // Clock and run limit.
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t ns: timeout with %0d words outstanding",
                     $time, pending_results.size());
            $display("three_operand_cpu_execute_unit verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Execute one instruction against the shadow state and return the
    // result word the unit must produce for it.
    // ------------------------------------------------------------------
    function automatic result_word_t execute_instr(input instr_word_t w);
        logic [RF_AW-1:0] rd, rs, rt, rm;
        logic [XLEN-1:0]  vs, vt, vm, rval, mval, addr;
        logic [PC_W-1:0]  seq, npc, maddr;
        logic [4:0]       sh;
        logic             rw, mw, flt, taken;
        result_word_t     r;

        rd    = RF_AW'(w.dest_index  % REG_COUNT);
        rs    = RF_AW'(w.src_s_index % REG_COUNT);
        rt    = RF_AW'(w.src_t_index % REG_COUNT);
        rm    = RF_AW'(w.src_m_index % REG_COUNT);
        vs    = arch_regs[rs];
        vt    = arch_regs[rt];
        vm    = arch_regs[rm];
        seq   = arch_pc + 1'b1;
        npc   = seq;
        sh    = vt[4:0];
        rw    = 1'b0;
        mw    = 1'b0;
        flt   = 1'b0;
        taken = 1'b0;
        rval  = '0;
        mval  = '0;
        maddr = '0;

        case (w.command)
            CMD_ADD: begin rval = vs + vt + vm;        rw = 1'b1; end
            CMD_SUB: begin rval = vs - vt - vm;        rw = 1'b1; end
            CMD_MAC: begin rval = vs * vt + vm;        rw = 1'b1; end
            CMD_AND: begin rval = vs & vt & vm;        rw = 1'b1; end
            CMD_OR:  begin rval = vs | vt | vm;        rw = 1'b1; end
            CMD_XOR: begin rval = vs ^ vt ^ vm;        rw = 1'b1; end
            CMD_SLL: begin rval = vs << sh;            rw = 1'b1; end
            CMD_SRA: begin rval = $signed(vs) >>> sh;  rw = 1'b1; end
            CMD_SRL: begin rval = vs >> sh;            rw = 1'b1; end
            CMD_BEQ, CMD_BNE, CMD_BLT, CMD_BGT, CMD_BLE, CMD_BGE:
            begin
                case (w.command)
                    CMD_BEQ: taken = $signed(vs) == $signed(vt);
                    CMD_BNE: taken = $signed(vs) != $signed(vt);
                    CMD_BLT: taken = $signed(vs) <  $signed(vt);
                    CMD_BGT: taken = $signed(vs) >  $signed(vt);
                    CMD_BLE: taken = $signed(vs) <= $signed(vt);
                    default: taken = $signed(vs) >= $signed(vt);
                endcase
                if (taken)
                begin
                    npc = vm[PC_W-1:0];
                    n_taken++;
                end
            end
            CMD_JAL:
            begin
                // link lands first, so rd == rm jumps to the link value
                arch_regs[rd] = XLEN'(seq);
                npc  = arch_regs[rm][PC_W-1:0];
                rval = XLEN'(seq);
                rw   = 1'b1;
                n_jumps++;
            end
            CMD_LW, CMD_SW:
            begin
                addr  = vs + vt;
                maddr = addr[PC_W-1:0];
                if (addr >= MEM_WORDS)
                begin
                    flt = 1'b1;
                    npc = arch_pc;
                    n_faults++;
                end
                else if (w.command == CMD_LW)
                begin
                    mval = arch_mem[addr[DM_AW-1:0]];
                    rval = mval + vm;
                    rw   = 1'b1;
                    n_loads++;
                end
                else
                begin
                    mval = arch_regs[rd] + vm;
                    arch_mem[addr[DM_AW-1:0]] = mval;
                    mw   = 1'b1;
                    n_stores++;
                end
            end
            CMD_SETREG:
            begin
                rval = w.load_value;
                rw   = 1'b1;
                npc  = arch_pc;
            end
            default: ;
        endcase

        if (rw)
            arch_regs[rd] = rval;
        arch_pc = npc;

        r.next_pc     = arch_pc;
        r.reg_written = rw;
        r.reg_index   = rw ? IDX_W'(rd) : '0;
        r.reg_value   = rw ? rval : '0;
        r.mem_written = mw;
        r.mem_address = maddr;
        r.mem_value   = mval;
        r.fault       = flt;
        return r;
    endfunction

    function automatic instr_word_t make_word(input logic [CMD_W-1:0] cmd,
                                              input logic [IDX_W-1:0] d,
                                              input logic [IDX_W-1:0] s,
                                              input logic [IDX_W-1:0] t,
                                              input logic [IDX_W-1:0] m,
                                              input logic [XLEN-1:0]  value);
        instr_word_t w;
        w.command     = cmd;
        w.dest_index  = d;
        w.src_s_index = s;
        w.src_t_index = t;
        w.src_m_index = m;
        w.load_value  = value;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Random pickers. Indices lean toward r0..r3 so that back-to-back
    // words often touch the same register (forwarding paths).
    // ------------------------------------------------------------------
    function automatic logic [IDX_W-1:0] rand_index();
        if ($urandom_range(0, 1) == 1)
            return IDX_W'($urandom_range(0, 3));
        return IDX_W'($urandom_range(0, 15));
    endfunction

    // Mostly a small pool so loads hit earlier stores; some near the top
    // edge of memory and some far out of range.
    function automatic logic [XLEN-1:0] pick_address();
        int p;
        p = $urandom_range(0, 99);
        if (p < 65)
            return XLEN'($urandom_range(0, 31));
        if (p < 80)
            return XLEN'($urandom_range(0, MEM_WORDS - 1));
        if (p < 92)
            return XLEN'($urandom_range(MEM_WORDS - 8, MEM_WORDS - 1));
        return XLEN'($urandom_range(MEM_WORDS, 32'hFFFF_FFFF));
    endfunction

    // Small offsets, negative ones that wrap the 32-bit sum, and junk.
    function automatic logic [XLEN-1:0] pick_offset();
        int p;
        p = $urandom_range(0, 99);
        if (p < 75)
            return XLEN'($urandom_range(0, 3));
        if (p < 85)
            return XLEN'($urandom_range(0, MEM_WORDS - 1));
        if (p < 95)
            return XLEN'(0) - XLEN'($urandom_range(1, 4));
        return XLEN'($urandom());
    endfunction

    function automatic logic [XLEN-1:0] pick_value();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40)
            return XLEN'($urandom());
        if (p < 80)
            return XLEN'($urandom_range(0, MEM_WORDS - 1));
        case ($urandom_range(0, 4))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Send gap: mostly none or short, a few long, plus gap-free stretches.
    function automatic int next_gap();
        int p;
        if (tx_run > 0)
        begin
            tx_run--;
            return 0;
        end
        p = $urandom_range(0, 99);
        if (p < 3)
        begin
            tx_run = $urandom_range(20, 80);
            return 0;
        end
        if (p < 55)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Instruction side. Entered and left at a falling edge; valid stays
    // high across back-to-back words and is only lowered for a gap or a drain.
    // ------------------------------------------------------------------
    task automatic send_word(input instr_word_t w);
        int gap;
        begin
            gap = next_gap();
            if (gap > 0)
            begin
                instr_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            instr_valid <= 1'b1;
            instr       <= w;
            do
                @(posedge clk);
            while (!instr_ready);
            pending_results.push_back(execute_instr(w));
            words_sent++;
            @(negedge clk);
        end
    endtask

    // Hold off the sender until every predicted word has come back.
    task automatic wait_for_results();
        begin
            instr_valid <= 1'b0;
            @(negedge clk);
            while (pending_results.size() != 0)
                @(negedge clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: ready toggles at the falling edge. Mostly short stalls,
    // occasional long ones, and stretches of solid ready.
    // ------------------------------------------------------------------
    initial
    begin
        int p;
        result_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (rx_run > 0)
            begin
                rx_run--;
                result_ready <= 1'b1;
            end
            else if (rx_stall > 0)
            begin
                rx_stall--;
                result_ready <= 1'b0;
            end
            else
            begin
                p = $urandom_range(0, 99);
                if (p < 5)
                begin
                    rx_run = $urandom_range(30, 150);
                    result_ready <= 1'b1;
                end
                else if (p < 8)
                begin
                    rx_stall = $urandom_range(10, 40);
                    result_ready <= 1'b0;
                end
                else if (p < 35)
                    result_ready <= 1'b0;
                else
                    result_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted word against the oldest prediction.
    // ------------------------------------------------------------------
    function automatic int field_mismatch(input string field,
                                          input logic [XLEN-1:0] want,
                                          input logic [XLEN-1:0] got);
        if (got === want)
            return 0;
        if (mismatches < MAX_REPORTS)
            $display("%0t ns: %s expected %h, got %h", $time, field, want, got);
        return 1;
    endfunction

    always @(posedge clk)
    begin
        result_word_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t ns: unexpected result word, expected none, got %h",
                             $time, result);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                mismatches += field_mismatch("next_pc", XLEN'(want.next_pc),
                                             XLEN'(result.next_pc));
                mismatches += field_mismatch("reg_written", XLEN'(want.reg_written),
                                             XLEN'(result.reg_written));
                mismatches += field_mismatch("reg_index", XLEN'(want.reg_index),
                                             XLEN'(result.reg_index));
                mismatches += field_mismatch("reg_value", want.reg_value,
                                             result.reg_value);
                mismatches += field_mismatch("mem_written", XLEN'(want.mem_written),
                                             XLEN'(result.mem_written));
                mismatches += field_mismatch("mem_address", XLEN'(want.mem_address),
                                             XLEN'(result.mem_address));
                mismatches += field_mismatch("mem_value", want.mem_value,
                                             result.mem_value);
                mismatches += field_mismatch("fault", XLEN'(want.fault),
                                             XLEN'(result.fault));
                words_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed tests. They run in order and build on each other's
    // register contents:
    //   r1 = 0x8000_0000, r2 = 0x7FFF_FFFF, r15 = all ones, r12 = 1.
    // ------------------------------------------------------------------

    // Every ALU op on the signed extremes; shift amount 31 from r15.
    task automatic test_alu_extremes();
        begin
            send_word(make_word(CMD_SETREG, 4'd1,  4'd0, 4'd0, 4'd0, 32'h8000_0000));
            send_word(make_word(CMD_SETREG, 4'd2,  4'd0, 4'd0, 4'd0, 32'h7FFF_FFFF));
            send_word(make_word(CMD_SETREG, 4'd15, 4'd0, 4'd0, 4'd0, 32'hFFFF_FFFF));
            send_word(make_word(CMD_ADD, 4'd4,  4'd1,  4'd2,  4'd15, '0));
            send_word(make_word(CMD_SUB, 4'd5,  4'd1,  4'd2,  4'd15, '0));
            send_word(make_word(CMD_MAC, 4'd6,  4'd2,  4'd2,  4'd1,  '0));
            send_word(make_word(CMD_AND, 4'd7,  4'd15, 4'd1,  4'd2,  '0));
            send_word(make_word(CMD_OR,  4'd8,  4'd1,  4'd2,  4'd15, '0));
            send_word(make_word(CMD_XOR, 4'd9,  4'd1,  4'd2,  4'd15, '0));
            send_word(make_word(CMD_SLL, 4'd10, 4'd15, 4'd15, 4'd0,  '0));
            send_word(make_word(CMD_SRA, 4'd11, 4'd1,  4'd15, 4'd0,  '0));
            send_word(make_word(CMD_SRL, 4'd12, 4'd1,  4'd15, 4'd0,  '0));
        end
    endtask

    // Branch targets come from r15, masked to 4095, and once from r14; the PC
    // wraps both on a plain advance and as the jal link value.
    task automatic test_branch_and_jump();
        begin
            send_word(make_word(CMD_BEQ, 4'd0,  4'd0, 4'd0, 4'd15, '0));
            // at PC 4095: link wraps to 0, rd == rm so jump lands on 0
            send_word(make_word(CMD_JAL, 4'd14, 4'd0, 4'd0, 4'd14, '0));
            send_word(make_word(CMD_BNE, 4'd0,  4'd1, 4'd2, 4'd15, '0));
            send_word(make_word(CMD_BLT, 4'd0,  4'd2, 4'd1, 4'd15, '0));
            send_word(make_word(CMD_BGT, 4'd0,  4'd2, 4'd1, 4'd15, '0));
            send_word(make_word(CMD_BLE, 4'd0,  4'd1, 4'd1, 4'd14, '0));
            send_word(make_word(CMD_BGE, 4'd0,  4'd1, 4'd2, 4'd15, '0));
        end
    endtask

    // Store then load the same word, load-use, top address, out-of-range
    // fault, and a 32-bit address sum that wraps back into range.
    task automatic test_memory_and_faults();
        begin
            send_word(make_word(CMD_SETREG, 4'd3, 4'd0, 4'd0, 4'd0, 32'h0000_0FFF));
            send_word(make_word(CMD_SW,  4'd2,  4'd12, 4'd0,  4'd12, '0));
            send_word(make_word(CMD_LW,  4'd13, 4'd12, 4'd0,  4'd15, '0));
            send_word(make_word(CMD_ADD, 4'd5,  4'd13, 4'd13, 4'd0,  '0));
            send_word(make_word(CMD_LW,  4'd4,  4'd3,  4'd0,  4'd0,  '0));
            send_word(make_word(CMD_LW,  4'd4,  4'd3,  4'd12, 4'd0,  '0));
            send_word(make_word(CMD_SW,  4'd1,  4'd15, 4'd12, 4'd0,  '0));
        end
    endtask

    task automatic test_unused_commands();
        begin
            send_word(make_word(CMD_FIRST_UNUSED, 4'd0, 4'd0, 4'd0, 4'd0, '0));
            send_word(make_word(CMD_LAST_UNUSED, 4'd15, 4'd15, 4'd15, 4'd15,
                                32'hFFFF_FFFF));
        end
    endtask

    // ------------------------------------------------------------------
    // Random traffic. Most memory words come in well-formed bursts: an
    // address and an offset are set first so the access usually lands in
    // range. The rest is ALU, branch, jal, loads feeding the next word,
    // and stray accesses through whatever the registers hold.
    // ------------------------------------------------------------------
    task automatic test_random_traffic(input int target);
        int               issued;
        int               next_drain;
        int               p;
        int               n;
        logic [IDX_W-1:0] ra, rb, rx;
        begin
            issued     = 0;
            next_drain = DRAIN_EVERY;
            while (issued < target)
            begin
                p = $urandom_range(0, 99);
                if (p < 35)
                begin
                    ra = rand_index();
                    rb = ra + IDX_W'($urandom_range(1, 15));
                    send_word(make_word(CMD_SETREG, ra, 4'd0, 4'd0, 4'd0, pick_address()));
                    send_word(make_word(CMD_SETREG, rb, 4'd0, 4'd0, 4'd0, pick_offset()));
                    n = $urandom_range(1, 4);
                    repeat (n)
                        send_word(make_word($urandom_range(0, 1) ? CMD_LW : CMD_SW,
                                            rand_index(), ra, rb, rand_index(),
                                            XLEN'($urandom())));
                    issued += 2 + n;
                end
                else if (p < 60)
                begin
                    send_word(make_word(CMD_W'($urandom_range(CMD_ADD, CMD_SRL)),
                                        rand_index(), rand_index(), rand_index(),
                                        rand_index(), XLEN'($urandom())));
                    issued++;
                end
                else if (p < 72)
                begin
                    send_word(make_word(CMD_W'($urandom_range(CMD_BEQ, CMD_BGE)),
                                        rand_index(), rand_index(), rand_index(),
                                        rand_index(), XLEN'($urandom())));
                    issued++;
                end
                else if (p < 77)
                begin
                    send_word(make_word(CMD_JAL, rand_index(), rand_index(),
                                        rand_index(), rand_index(), XLEN'($urandom())));
                    issued++;
                end
                else if (p < 87)
                begin
                    send_word(make_word(CMD_SETREG, rand_index(), rand_index(),
                                        rand_index(), rand_index(), pick_value()));
                    issued++;
                end
                else if (p < 89)
                begin
                    send_word(make_word(CMD_W'($urandom_range(CMD_FIRST_UNUSED,
                                                              CMD_LAST_UNUSED)),
                                        rand_index(), rand_index(), rand_index(),
                                        rand_index(), XLEN'($urandom())));
                    issued++;
                end
                else if (p < 92)
                begin
                    // address from live register contents: mostly faults
                    send_word(make_word($urandom_range(0, 1) ? CMD_LW : CMD_SW,
                                        rand_index(), rand_index(), rand_index(),
                                        rand_index(), XLEN'($urandom())));
                    issued++;
                end
                else
                begin
                    // load, then a word that needs the loaded register at once
                    ra = rand_index();
                    rx = rand_index();
                    send_word(make_word(CMD_SETREG, ra, 4'd0, 4'd0, 4'd0,
                                        XLEN'($urandom_range(0, 15))));
                    send_word(make_word(CMD_LW, rx, ra, ra, rand_index(), '0));
                    case ($urandom_range(0, 3))
                        0: send_word(make_word(CMD_W'($urandom_range(CMD_ADD, CMD_SRL)),
                                               rand_index(), rx, rand_index(),
                                               rand_index(), '0));
                        1: send_word(make_word(CMD_W'($urandom_range(CMD_ADD, CMD_SRL)),
                                               rand_index(), rand_index(), rx, rx, '0));
                        2: send_word(make_word(CMD_W'($urandom_range(CMD_BEQ, CMD_BGE)),
                                               4'd0, rx, rand_index(), rand_index(), '0));
                        default: send_word(make_word(CMD_SW, rx, ra, ra,
                                                     rand_index(), '0));
                    endcase
                    issued += 3;
                end

                if (issued >= next_drain)
                begin
                    wait_for_results();
                    next_drain += DRAIN_EVERY;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        instr_valid   = 1'b0;
        instr         = '0;
        arch_pc       = '0;
        mismatches    = 0;
        words_sent    = 0;
        words_checked = 0;
        n_loads       = 0;
        n_stores      = 0;
        n_faults      = 0;
        n_taken       = 0;
        n_jumps       = 0;
        cycle_count   = 0;
        tx_run        = 0;
        rx_run        = 0;
        rx_stall      = 0;
        foreach (arch_regs[i])
            arch_regs[i] = '0;
        foreach (arch_mem[i])
            arch_mem[i] = '0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // the clear sweep keeps instr_ready low; send_word just waits it out
        test_alu_extremes();
        test_branch_and_jump();
        test_memory_and_faults();
        test_unused_commands();
        test_random_traffic(RANDOM_WORDS);

        wait_for_results();
        repeat (20) @(negedge clk);

        $display("Ran %0d instructions, %0d results checked: %0d loads, %0d stores,",
                 words_sent, words_checked, n_loads, n_stores);
        $display("%0d memory faults, %0d taken branches, %0d jumps; %0d mismatches.",
                 n_faults, n_taken, n_jumps, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("three_operand_cpu_execute_unit verification clean");
        else
            $display("three_operand_cpu_execute_unit verification failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/toeu_pkg.sv
hw/rtl/toeu_ram_2r.sv
hw/rtl/toeu_alu.sv
hw/rtl/three_operand_cpu_execute_unit.sv
test/tb_three_operand_cpu_execute_unit.sv
